// ===== rtl/core/bbalc_pkg.sv =====
// shared types, sizes and helper functions of the buddy block allocator
`default_nettype none

package bbalc_pkg;

   localparam int POOL_BYTES      = 2048;
   localparam int MIN_BLOCK_BYTES = 64;

   localparam int SIZE_W = 12;
   localparam int ADDR_W = 11;

   // deepest level whose block still holds MIN_BLOCK_BYTES
   function automatic int calc_leaf_depth();
      int d;
      d = 0;
      while (d + 1 < 32 && (POOL_BYTES >> (d + 1)) >= MIN_BLOCK_BYTES) d++;
      return d;
   endfunction

   localparam int LEAF_DEPTH = calc_leaf_depth();
   localparam int NODE_COUNT = (2 << LEAF_DEPTH) - 1;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int DEPTH_W    = $clog2(LEAF_DEPTH + 1);
   localparam int ORDER_W    = $clog2(LEAF_DEPTH + 2);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      RSP_OK      = 2'd0,
      RSP_NO_ROOM = 2'd1,
      RSP_BAD     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_UP_READ,
      ST_UP_WRITE
   } state_type;

   typedef struct packed {
      logic                 mark;
      logic [ORDER_W-1:0]   order;
   } node_type;

   typedef struct packed {
      logic       load;
      logic       rd_down;
      logic       rd_up;
      logic       descend;
      logic       mark_write;
      logic       refresh_write;
      logic       respond;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic bad_size;
      logic no_room;
      logic at_target;
      logic mark_set;
      logic addr_match;
      logic at_root;
      logic at_leaf;
   } stat_type;

   // bytes held by a free block of the given order code, zero for none
   function automatic logic [SIZE_W-1:0] code_bytes(input logic [ORDER_W-1:0] order);
      logic [ORDER_W-1:0] shamt;
      shamt = ORDER_W'(LEAF_DEPTH + 1) - order;
      if (order == '0) return '0;
      return SIZE_W'(POOL_BYTES) >> shamt;
   endfunction

   // size of each child block below a node at this depth
   function automatic logic [SIZE_W-1:0] half_bytes(input logic [DEPTH_W-1:0] depth);
      return SIZE_W'(POOL_BYTES) >> ({1'b0, depth} + 1'b1);
   endfunction

   function automatic logic [ORDER_W-1:0] full_order(input logic [DEPTH_W-1:0] depth);
      return ORDER_W'(LEAF_DEPTH + 1) - ORDER_W'(depth);
   endfunction

   // level of a node in heap order
   function automatic logic [DEPTH_W-1:0] node_depth(input logic [NODE_W-1:0] idx);
      logic [DEPTH_W-1:0] d;
      d = '0;
      for (int k = 1; k <= LEAF_DEPTH; k++) begin
         if ({1'b0, idx} + 1'b1 >= (NODE_W + 1)'(1 << k)) d = DEPTH_W'(k);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bbalc_node_ram.sv =====
// node store: free order and allocated mark per tree node, two registered read ports
`default_nettype none

module bbalc_node_ram
   import bbalc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [NODE_W-1:0] rd_a_addr,
   input  wire logic [NODE_W-1:0] rd_b_addr,
   output node_type               rd_a_data,
   output node_type               rd_b_data,
   input  wire logic              wr_en,
   input  wire logic [NODE_W-1:0] wr_addr,
   input  wire node_type          wr_data
);

   node_type               mem [NODE_COUNT];
   logic [NODE_COUNT-1:0]  valid_ff;
   logic [NODE_COUNT-1:0]  valid_in;
   node_type               rd_a_ff;
   node_type               rd_b_ff;
   node_type               rd_a_in;
   node_type               rd_b_in;
   node_type               mem_a_ff;
   node_type               mem_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      mem_a_ff <= mem[rd_a_addr];
      mem_b_ff <= mem[rd_b_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) valid_in[wr_addr] = 1'b1;
   end

   // entries never written read as a wholly free block of their own size
   always_comb begin
      rd_a_in.mark  = 1'b0;
      rd_a_in.order = full_order(node_depth(rd_a_addr));
      rd_b_in.mark  = 1'b0;
      rd_b_in.order = full_order(node_depth(rd_b_addr));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rd_a_ff <= rd_a_in;
      rd_b_ff <= rd_b_in;
   end

   logic use_a_ff;
   logic use_b_ff;

   always_ff @(posedge clock) begin
      use_a_ff <= valid_ff[rd_a_addr];
      use_b_ff <= valid_ff[rd_b_addr];
   end

   assign rd_a_data = use_a_ff ? mem_a_ff : rd_a_ff;
   assign rd_b_data = use_b_ff ? mem_b_ff : rd_b_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bbalc_ctrl.sv =====
// controller state machine: sequences the tree walk down and the refresh back up
`default_nettype none

module bbalc_ctrl
   import bbalc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.is_alloc) begin
               if (stat.at_root && (stat.bad_size || stat.no_room)) state_in = ST_IDLE;
               else if (stat.at_target) state_in = stat.at_root ? ST_IDLE : ST_UP_READ;
               else state_in = ST_READ;
            end else begin
               if (stat.mark_set) begin
                  if (!stat.addr_match || stat.at_root) state_in = ST_IDLE;
                  else state_in = ST_UP_READ;
               end else if (stat.at_leaf) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_UP_READ: begin
            state_in = ST_UP_WRITE;
         end
         ST_UP_WRITE: begin
            state_in = stat.at_root ? ST_IDLE : ST_UP_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      cmd.code = RSP_OK;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_READ: begin
            cmd.rd_down = 1'b1;
         end
         ST_EVAL: begin
            if (stat.is_alloc) begin
               if (stat.at_root && stat.bad_size) begin
                  cmd.respond = 1'b1;
                  cmd.code    = RSP_BAD;
               end else if (stat.at_root && stat.no_room) begin
                  cmd.respond = 1'b1;
                  cmd.code    = RSP_NO_ROOM;
               end else if (stat.at_target) begin
                  cmd.mark_write = 1'b1;
                  cmd.respond    = stat.at_root;
               end else begin
                  cmd.descend = 1'b1;
               end
            end else begin
               if (stat.mark_set) begin
                  if (!stat.addr_match) begin
                     cmd.respond = 1'b1;
                     cmd.code    = RSP_BAD;
                  end else begin
                     cmd.mark_write = 1'b1;
                     cmd.respond    = stat.at_root;
                  end
               end else if (stat.at_leaf) begin
                  cmd.respond = 1'b1;
                  cmd.code    = RSP_BAD;
               end else begin
                  cmd.descend = 1'b1;
               end
            end
         end
         ST_UP_READ: begin
            cmd.rd_up = 1'b1;
         end
         ST_UP_WRITE: begin
            cmd.refresh_write = 1'b1;
            cmd.respond       = stat.at_root;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/bbalc_datapath.sv =====
// datapath: request registers, walk position, node store access and result register
`default_nettype none

module bbalc_datapath
   import bbalc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_opcode,
   input  wire logic [SIZE_W-1:0] req_request_size,
   input  wire logic [ADDR_W-1:0] req_free_address,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [ADDR_W-1:0]      rsp_block_address
);

   opcode_type          op_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [ADDR_W-1:0]   ptr_ff;
   logic [NODE_W-1:0]   node_ff,  node_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [ADDR_W-1:0]   addr_ff,  addr_in;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;

   logic [NODE_W-1:0]   rd_a_addr, rd_b_addr, wr_addr;
   node_type            rd_a_data, rd_b_data, wr_data;
   logic                wr_en;

   logic [SIZE_W-1:0]   half;
   logic [SIZE_W-1:0]   split_point;
   logic [NODE_W-1:0]   left_child;
   logic [NODE_W-1:0]   pair_left;
   logic                go_right;
   logic [ORDER_W-1:0]  child_full;
   logic [ORDER_W-1:0]  refreshed;

   bbalc_node_ram u_node_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   assign half        = half_bytes(depth_ff);
   assign split_point = {1'b0, addr_ff} + half;
   assign left_child  = {node_ff[NODE_W-2:0], 1'b1};
   assign pair_left   = node_ff[0] ? node_ff : node_ff - 1'b1;
   assign child_full  = ORDER_W'(LEAF_DEPTH) - ORDER_W'(depth_ff);

   always_comb begin
      if (op_ff == OP_ALLOC) go_right = code_bytes(rd_b_data.order) < size_ff;
      else                   go_right = {1'b0, ptr_ff} >= split_point;
   end

   // parent merges when both children are wholly free blocks
   always_comb begin
      if (rd_a_data.order == child_full && rd_b_data.order == child_full)
         refreshed = child_full + 1'b1;
      else if (rd_a_data.order > rd_b_data.order)
         refreshed = rd_a_data.order;
      else
         refreshed = rd_b_data.order;
   end

   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = '0;
      if (cmd.rd_down) begin
         rd_a_addr = node_ff;
         if (depth_ff < DEPTH_W'(LEAF_DEPTH)) rd_b_addr = left_child;
      end else if (cmd.rd_up) begin
         rd_a_addr = pair_left;
         rd_b_addr = pair_left + 1'b1;
      end
   end

   always_comb begin
      wr_en   = cmd.mark_write || cmd.refresh_write;
      wr_addr = node_ff;
      wr_data.mark  = 1'b0;
      wr_data.order = refreshed;
      if (cmd.mark_write) begin
         if (op_ff == OP_ALLOC) begin
            wr_data.mark  = 1'b1;
            wr_data.order = '0;
         end else begin
            wr_data.order = full_order(depth_ff);
         end
      end
   end

   always_comb begin
      node_in  = node_ff;
      depth_in = depth_ff;
      addr_in  = addr_ff;
      if (cmd.load) begin
         node_in  = '0;
         depth_in = '0;
         addr_in  = '0;
      end else if (cmd.descend) begin
         node_in  = go_right ? left_child + 1'b1 : left_child;
         depth_in = depth_ff + 1'b1;
         if (go_right) addr_in = split_point[ADDR_W-1:0];
      end else if (cmd.rd_up) begin
         node_in  = (node_ff - 1'b1) >> 1;
         depth_in = depth_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         node_ff      <= '0;
         depth_ff     <= '0;
         addr_ff      <= '0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         node_ff      <= node_in;
         depth_ff     <= depth_in;
         addr_ff      <= addr_in;
      end
      if (cmd.load) begin
         op_ff   <= opcode_type'(req_opcode);
         size_ff <= req_request_size;
         ptr_ff  <= req_free_address;
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.code;
         rsp_addr_ff   <= (cmd.code == RSP_OK && op_ff == OP_ALLOC) ? addr_ff : '0;
      end
   end

   always_comb begin
      stat.is_alloc   = (op_ff == OP_ALLOC);
      stat.bad_size   = (size_ff == '0) || (size_ff > SIZE_W'(POOL_BYTES));
      stat.no_room    = size_ff > code_bytes(rd_a_data.order);
      stat.at_leaf    = (depth_ff == DEPTH_W'(LEAF_DEPTH));
      stat.at_root    = (depth_ff == '0);
      stat.at_target  = stat.at_leaf || (size_ff > half);
      stat.mark_set   = rd_a_data.mark;
      stat.addr_match = (addr_ff == ptr_ff);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(LEAF_DEPTH))
      else $error("walk depth beyond leaf level");

   a_up_not_root: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_up |-> depth_ff != '0)
      else $error("upward step requested at the root");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

// ===== rtl/core/buddy_block_allocator_core.sv =====
// top level of the buddy block allocator: controller plus datapath
//
//   channel   ports                                          handshake
//   request   req_opcode, req_request_size, req_free_address start & !busy
//   result    rsp_status, rsp_block_address                  rsp_valid, one cycle
//
// a request that finds its block at depth d (root is depth 0) walks down level by
// level (node store read, then decide) and refreshes back up level by level (read
// the child pair, then write the parent); the split into read and write steps is set
// by the registered read of the node store. rejected requests end at the level where
// they fail. the strobe shows in the same cycle that busy drops, so the next start is
// taken while the result is out. synchronous reset frees the whole pool at once;
// results cannot be stalled.
`default_nettype none

module buddy_block_allocator_core
   import bbalc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_opcode,
   input  wire logic [SIZE_W-1:0] req_request_size,
   input  wire logic [ADDR_W-1:0] req_free_address,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [ADDR_W-1:0]      rsp_block_address
);

   cmd_type  cmd;
   stat_type stat;

   bbalc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bbalc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_request_size  (req_request_size),
      .req_free_address  (req_free_address),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address)
   );

endmodule

`default_nettype wire
